// ===== src/fmva_pkg.sv =====
// ============================================================================
// FM voice allocator package
// Shared widths, channel count and action and event codes.
// ============================================================================
package fmva_pkg;

    localparam int CHANNELS  = 8;
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int ACTION_W  = 3;
    localparam int NOTE_W    = 4;
    localparam int OCT_W     = 3;
    localparam int KIND_W    = 2;
    localparam int CHAN_W    = 3;
    localparam int MASK_W    = 4;

    localparam logic [OCT_W-1:0]  OCT_MIN    = 3'd1;
    localparam logic [OCT_W-1:0]  OCT_MAX    = 3'd7;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 3'd3;
    localparam logic [MASK_W-1:0] MASK_RESET = 4'd15;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NOTE_ON  = 3'd0,
        ACT_NOTE_OFF = 3'd1,
        ACT_OCT_DOWN = 3'd2,
        ACT_OCT_UP   = 3'd3,
        ACT_STOP_ALL = 3'd4
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 2'd0,
        EV_KEY_ON  = 2'd1,
        EV_KEY_OFF = 2'd2,
        EV_ALL_OFF = 2'd3
    } t_event;

endpackage

// ===== src/fmva_if.sv =====
// ============================================================================
// FM voice allocator channel interfaces
// Valid/ready channels for input items, result items and the mask register.
// ============================================================================
interface fmva_in_if;
    logic                           valid;
    logic                           ready;
    logic [fmva_pkg::ACTION_W-1:0]  action;
    logic [fmva_pkg::NOTE_W-1:0]    note;

    modport source (output valid, output action, output note, input ready);
    modport sink   (input valid, input action, input note, output ready);
endinterface

interface fmva_out_if;
    logic                           valid;
    logic                           ready;
    logic [fmva_pkg::KIND_W-1:0]    event_kind;
    logic [fmva_pkg::CHAN_W-1:0]    channel;
    logic [fmva_pkg::OCT_W-1:0]     out_octave;
    logic [fmva_pkg::NOTE_W-1:0]    out_note;
    logic [fmva_pkg::MASK_W-1:0]    out_mask;

    modport source (output valid, output event_kind, output channel, output out_octave,
                    output out_note, output out_mask, input ready);
    modport sink   (input valid, input event_kind, input channel, input out_octave,
                    input out_note, input out_mask, output ready);
endinterface

interface fmva_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fmva_pkg::MASK_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fm_voice_allocator.sv =====
// ============================================================================
// FM voice allocator
// An accepted item's result enters the output register in the next cycle.
// Throughput: one item per cycle while the output is taken; the free-channel and
// note-match priority encoders over the channel table settle an item in one pass.
// Reset: all channels free, current octave 3, operator mask 15, output empty.
// ============================================================================
module fm_voice_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmva_in_if.sink     i_in,
    fmva_out_if.source  o_out,
    fmva_cfg_if.sink    i_cfg
);
    import fmva_pkg::*;

    logic [CHANNELS-1:0]    r_busy;
    logic [CHANNELS-1:0]    n_busy;
    logic [OCT_W-1:0]       r_held_oct [CHANNELS];
    logic [NOTE_W-1:0]      r_held_note [CHANNELS];
    logic [OCT_W-1:0]       r_cur_oct;
    logic [OCT_W-1:0]       n_cur_oct;
    logic [MASK_W-1:0]      r_mask;

    logic                   r_out_valid;
    logic [KIND_W-1:0]      r_kind;
    logic [CHAN_W-1:0]      r_chan;
    logic [OCT_W-1:0]       r_oct;
    logic [NOTE_W-1:0]      r_note;
    logic [MASK_W-1:0]      r_omask;
    logic [KIND_W-1:0]      n_kind;
    logic [CHAN_W-1:0]      n_chan;
    logic [OCT_W-1:0]       n_oct;
    logic [NOTE_W-1:0]      n_note;
    logic [MASK_W-1:0]      n_omask;
    logic                   n_alloc;

    logic                   accept;
    logic                   free_found;
    logic [CH_IDX_W-1:0]    free_idx;
    logic                   match_found;
    logic [CH_IDX_W-1:0]    match_idx;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        free_found  = 1'b0;
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = CH_IDX_W'(i);
            end
            if (r_busy[i] && r_held_oct[i] == r_cur_oct && r_held_note[i] == i_in.note) begin
                match_found = 1'b1;
                match_idx   = CH_IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_cur_oct = r_cur_oct;
        n_alloc   = 1'b0;
        n_kind    = EV_NONE;
        n_chan    = '0;
        n_note    = '0;
        n_omask   = '0;
        case (i_in.action)
            ACT_NOTE_ON: begin
                if (free_found) begin
                    n_busy[free_idx] = 1'b1;
                    n_alloc = 1'b1;
                    n_kind  = EV_KEY_ON;
                    n_chan  = CHAN_W'(free_idx);
                    n_note  = i_in.note;
                    n_omask = r_mask;
                end
            end
            ACT_NOTE_OFF: begin
                if (match_found) begin
                    n_busy[match_idx] = 1'b0;
                    n_kind = EV_KEY_OFF;
                    n_chan = CHAN_W'(match_idx);
                    n_note = i_in.note;
                end
            end
            ACT_OCT_DOWN: begin
                if (r_cur_oct > OCT_MIN) begin
                    n_cur_oct = r_cur_oct - OCT_W'(1);
                end
            end
            ACT_OCT_UP: begin
                if (r_cur_oct < OCT_MAX) begin
                    n_cur_oct = r_cur_oct + OCT_W'(1);
                end
            end
            ACT_STOP_ALL: begin
                n_busy = '0;
                n_kind = EV_ALL_OFF;
            end
            default: begin
                n_kind = EV_NONE;
            end
        endcase
        n_oct = n_cur_oct;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_cur_oct   <= OCT_RESET;
            r_mask      <= MASK_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_mask <= i_cfg.data;
            end
            if (accept) begin
                r_busy      <= n_busy;
                r_cur_oct   <= n_cur_oct;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= n_kind;
            r_chan  <= n_chan;
            r_oct   <= n_oct;
            r_note  <= n_note;
            r_omask <= n_omask;
            if (n_alloc) begin
                r_held_oct[free_idx]  <= r_cur_oct;
                r_held_note[free_idx] <= i_in.note;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_kind;
    assign o_out.channel    = r_chan;
    assign o_out.out_octave = r_oct;
    assign o_out.out_note   = r_note;
    assign o_out.out_mask   = r_omask;

endmodule

// ===== src/fmva_checker.sv =====
// ============================================================================
// FM voice allocator checker
// Port-level properties of the allocator, bound into the allocator module.
// ============================================================================
module fmva_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [fmva_pkg::ACTION_W-1:0]  i_in_action,
    input  logic                           i_out_valid,
    input  logic [fmva_pkg::KIND_W-1:0]    i_out_kind,
    input  logic [fmva_pkg::CHAN_W-1:0]    i_out_channel,
    input  logic [fmva_pkg::OCT_W-1:0]     i_out_octave,
    input  logic [fmva_pkg::MASK_W-1:0]    i_out_mask
);
    import fmva_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stop_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_action == ACT_STOP_ALL)
        |=> (i_out_valid && i_out_kind == EV_ALL_OFF))
        else $error("stop-all item did not give all-off");

    a_mask_key_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != EV_KEY_ON) |-> (i_out_mask == '0))
        else $error("operator mask shown on a non key-on result");

    a_octave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_octave != '0))
        else $error("octave out of range");

    a_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_kind == EV_NONE || i_out_kind == EV_ALL_OFF))
        |-> (i_out_channel == '0))
        else $error("channel set on a result without a keyed channel");

endmodule

bind fm_voice_allocator fmva_checker u_fmva_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_action   (i_in.action),
    .i_out_valid   (o_out.valid),
    .i_out_kind    (o_out.event_kind),
    .i_out_channel (o_out.channel),
    .i_out_octave  (o_out.out_octave),
    .i_out_mask    (o_out.out_mask)
);
